FILE: design/puncture_conformal_factor_unit_macros.svh
// ---------------------------------------------------------------------------
// puncture conformal factor assertion macros
// shared wrappers for the concurrent checks of the block
// ---------------------------------------------------------------------------
`ifndef PUNCTURE_CONFORMAL_FACTOR_UNIT_MACROS_SVH
`define PUNCTURE_CONFORMAL_FACTOR_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pcf_pkg.sv
// ---------------------------------------------------------------------------
// pcf_pkg
// types and constants of the puncture conformal factor unit
// ---------------------------------------------------------------------------
package pcf_pkg;

    localparam int MAX_PUNCTURES = 4;
    localparam int SLOT_W        = 2;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = $clog2(MAX_PUNCTURES);
    localparam int STEP_W        = 7;
    localparam int NUM_W         = 96;
    localparam int DEN_W         = 64;
    localparam int ENTRY_W       = 128;

    localparam logic [30:0] PSI_ONE = 31'h0001_0000;
    localparam logic [30:0] PSI_MAX = 31'h7FFF_FFFF;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [STEP_W-1:0] STEPS_ROOT_S   = 7'd33;
    localparam logic [STEP_W-1:0] STEPS_TERM     = 7'd47;
    localparam logic [STEP_W-1:0] STEPS_INV      = 7'd96;
    localparam logic [STEP_W-1:0] STEPS_CHI      = 7'd64;
    localparam logic [STEP_W-1:0] STEPS_LAPSE    = 7'd32;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_LOAD, S_SQX, S_SQY, S_SQZ, S_ACC,
        S_ROOT, S_ROOT_W, S_TERM, S_TERM_W,
        S_P2, S_INV, S_INV_W, S_CHI, S_CHI_W, S_LAP, S_LAP_W, S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic [STEP_W-1:0] steps;
    } t_iter_req;

endpackage

FILE: design/pcf_ram.sv
// ---------------------------------------------------------------------------
// pcf_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module pcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pcf_iter.sv
// ---------------------------------------------------------------------------
// pcf_iter
// shared restoring divider and square root, one result bit per cycle
// ---------------------------------------------------------------------------
module pcf_iter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pcf_pkg::t_iter_req       i_req,
    input  logic [pcf_pkg::NUM_W-1:0] i_num,
    input  logic [pcf_pkg::DEN_W-1:0] i_den,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [63:0]              o_q
);
    import pcf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_mode;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [65:0]       r_rem;
    logic [63:0]       r_q;
    logic [65:0]       rem_s;
    logic [65:0]       trial;
    logic              ge;
    logic [65:0]       n_rem;

    always_comb begin
        if (r_mode) begin
            rem_s = {r_rem[63:0], r_num[NUM_W-1 -: 2]};
            trial = {r_q, 2'b01};
        end else begin
            rem_s = {r_rem[64:0], r_num[NUM_W-1]};
            trial = {2'b00, r_den};
        end
        ge    = (rem_s >= trial);
        n_rem = ge ? (rem_s - trial) : rem_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_mode <= i_req.sqrt_mode;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_num <= r_mode ? {r_num[NUM_W-3:0], 2'b00} : {r_num[NUM_W-2:0], 1'b0};
                r_rem <= n_rem;
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

FILE: design/puncture_conformal_factor_unit.sv
// ---------------------------------------------------------------------------
// puncture_conformal_factor_unit
// brill-lindquist conformal factor chi = psi^-4 and lapse = sqrt(chi)
// ---------------------------------------------------------------------------
// A load transfer (tuser 0) writes one puncture into the table; an evaluate
// transfer (tuser 1) runs over n active punctures (a count above four counts
// as four) on the bit-serial divider and square root unit that all steps
// share. Per puncture: the table read and squaring states (read, load, sqx,
// sqy, sqz, acc), a 33-step root and a 47-step divide, each with a start
// state and a wait state. Then a psi^2 state, a 96-step and a 64-step divide
// and a 32-step root, each with a start state and a wait state, and a state
// that hands over to the output register; that last state stretches while an
// older result still waits there. The puncture table sits in a ram with
// registered read. A finished result waits in the output register while the
// next transfer is taken.
module puncture_conformal_factor_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // slot, mass, pos_x, pos_y, pos_z, zero pad
    input  logic [135:0]  s_axis_tdata,
    // func
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // chi_out, lapse_out
    output logic [63:0]   m_axis_tdata
);
    import pcf_pkg::*;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] r_n;
    logic [31:0]     r_px, r_py, r_pz;
    logic [31:0]     r_mass, r_dx, r_dy, r_dz;
    logic [63:0]     r_prod;
    logic [65:0]     r_acc;
    logic [32:0]     r_r;
    logic [30:0]     r_psi;
    logic [63:0]     r_t;
    logic [31:0]     r_chi;
    logic            r_out_valid;
    logic [31:0]     r_out_chi, r_out_lapse;
    logic [31:0]     r_out_lapse_q;

    logic            in_xfer;
    logic            ram_we;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [31:0]     mult_a;
    logic [31:0]     ad_x, ad_y, ad_z;
    t_iter_req       req;
    logic [NUM_W-1:0] it_num;
    logic [DEN_W-1:0] it_den;
    logic            it_busy, it_done;
    logic [63:0]     it_q;
    logic [47:0]     psi_sum;

    assign count_eff = (r_count > CNT_W'(MAX_PUNCTURES)) ? CNT_W'(MAX_PUNCTURES) : r_count;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign ram_we = in_xfer && (s_axis_tuser == FUNC_LOAD)
                    && ({1'b0, s_axis_tdata[SLOT_W-1:0]} < 3'(MAX_PUNCTURES));
    assign ram_wdata = s_axis_tdata[129:2];

    pcf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PUNCTURES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_n[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    assign ad_x = abs_diff(r_px, ram_rdata[63:32]);
    assign ad_y = abs_diff(r_py, ram_rdata[95:64]);
    assign ad_z = abs_diff(r_pz, ram_rdata[127:96]);
    assign psi_sum = {17'b0, r_psi} + it_q[47:0];

    always_comb begin
        case (r_state)
            S_SQY:   mult_a = r_dy;
            S_SQZ:   mult_a = r_dz;
            S_P2:    mult_a = {1'b0, r_psi};
            default: mult_a = r_dx;
        endcase
    end

    pcf_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_num   (it_num),
        .i_den   (it_den),
        .o_busy  (it_busy),
        .o_done  (it_done),
        .o_q     (it_q)
    );

    always_comb begin
        n_state = r_state;
        req     = '0;
        it_num  = '0;
        it_den  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && s_axis_tuser == FUNC_EVAL) begin
                    n_state = (count_eff == '0) ? S_P2 : S_READ;
                end
            end
            S_READ:   n_state = S_LOAD;
            S_LOAD:   n_state = S_SQX;
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_SQZ;
            S_SQZ:    n_state = S_ACC;
            S_ACC:    n_state = S_ROOT;
            S_ROOT: begin
                req     = '{start: 1'b1, sqrt_mode: 1'b1, steps: STEPS_ROOT_S};
                it_num  = {r_acc, 30'b0};
                n_state = S_ROOT_W;
            end
            S_ROOT_W: if (it_done) n_state = S_TERM;
            S_TERM: begin
                req     = '{start: 1'b1, sqrt_mode: 1'b0, steps: STEPS_TERM};
                it_num  = {r_mass, 15'b0, 49'b0};
                it_den  = {31'b0, r_r};
                n_state = S_TERM_W;
            end
            S_TERM_W: begin
                if (it_done) begin
                    n_state = (r_n + 1'b1 < count_eff) ? S_READ : S_P2;
                end
            end
            S_P2:     n_state = S_INV;
            S_INV: begin
                req     = '{start: 1'b1, sqrt_mode: 1'b0, steps: STEPS_INV};
                it_num  = {1'b1, 95'b0};
                it_den  = r_prod;
                n_state = S_INV_W;
            end
            S_INV_W:  if (it_done) n_state = S_CHI;
            S_CHI: begin
                req     = '{start: 1'b1, sqrt_mode: 1'b0, steps: STEPS_CHI};
                it_num  = {r_t, 32'b0};
                it_den  = r_prod;
                n_state = S_CHI_W;
            end
            S_CHI_W:  if (it_done) n_state = S_LAP;
            S_LAP: begin
                req     = '{start: 1'b1, sqrt_mode: 1'b1, steps: STEPS_LAPSE};
                it_num  = {1'b0, r_chi, 31'b0, 32'b0};
                n_state = S_LAP_W;
            end
            S_LAP_W:  if (it_done) n_state = S_OUT;
            S_OUT:    if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px  <= s_axis_tdata[65:34];
                r_py  <= s_axis_tdata[97:66];
                r_pz  <= s_axis_tdata[129:98];
                r_n   <= '0;
                r_psi <= PSI_ONE;
            end
            S_LOAD: begin
                r_mass <= ram_rdata[31:0];
                r_dx   <= ad_x;
                r_dy   <= ad_y;
                r_dz   <= ad_z;
            end
            S_SQX: begin
                r_prod <= mult_a * mult_a;
                r_acc  <= '0;
            end
            S_SQY, S_SQZ: begin
                r_prod <= mult_a * mult_a;
                r_acc  <= r_acc + {2'b0, r_prod};
            end
            S_ACC:    r_acc <= r_acc + {2'b0, r_prod};
            S_ROOT_W: if (it_done) r_r <= (it_q[32:0] == '0) ? 33'd1 : it_q[32:0];
            S_TERM_W: begin
                if (it_done) begin
                    r_psi <= (psi_sum > {17'b0, PSI_MAX}) ? PSI_MAX : psi_sum[30:0];
                    r_n   <= r_n + 1'b1;
                end
            end
            S_P2:     r_prod <= mult_a * mult_a;
            S_INV_W:  if (it_done) r_t <= it_q;
            S_CHI_W:  if (it_done) r_chi <= it_q[31:0];
            S_LAP_W:  if (it_done) r_out_lapse <= it_q[31:0];
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_chi     <= r_chi;
                    r_out_lapse_q <= r_out_lapse;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_lapse_q, r_out_chi};

`include "puncture_conformal_factor_unit_macros.svh"

    `PCF_ASSERT_SAME(a_idle_unit_free, r_state == S_IDLE, !it_busy, "iter unit busy in idle")
    `PCF_ASSERT_SAME(a_psi_range, r_state != S_IDLE, r_psi >= PSI_ONE, "psi below one")
    `PCF_ASSERT_SAME(a_chi_range, m_axis_tvalid, m_axis_tdata[31:0] <= 32'h8000_0000, "chi over one")
    `PCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, r_state != S_IDLE || m_axis_tvalid, "result dropped")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench for puncture_conformal_factor_unit
// drives load and evaluate transfers with random gaps and output stalls,
// predicts chi and lapse in exact integer arithmetic and compares each
// result transfer against the oldest expected value
// ---------------------------------------------------------------------------
module testbench;
    import pcf_pkg::*;

    localparam int  LIMIT_CYCLES = 4_000_000;
    localparam int  DRAIN_CYCLES = 24;

    // lapse in the upper half, chi in the lower half, as on the result bus
    typedef struct packed {
        logic [31:0] lapse;
        logic [31:0] chi;
    } t_field_out;

    class puncture_scoreboard;
        logic [2:0]  active_count;
        logic [31:0] mass_tab [MAX_PUNCTURES];
        logic [31:0] cx_tab [MAX_PUNCTURES];
        logic [31:0] cy_tab [MAX_PUNCTURES];
        logic [31:0] cz_tab [MAX_PUNCTURES];
        t_field_out  expected_q [$];
        int          mismatches;

        function new();
            active_count = 3'd0;
            mismatches   = 0;
        endfunction

        function logic [63:0] int_sqrt(input logic [127:0] v);
            logic [131:0] rem;
            logic [131:0] trial;
            logic [63:0]  root;
            rem  = '0;
            root = '0;
            for (int i = 63; i >= 0; i--) begin
                rem   = (rem << 2) | v[2*i +: 2];
                trial = ({68'd0, root} << 2) | 132'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function logic [127:0] abs_delta(input logic [31:0] a, input logic [31:0] b);
            logic signed [33:0] d;
            d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
            if (d < 0)
                d = -d;
            return {94'd0, d};
        endfunction

        function t_field_out conformal_field(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z);
            logic [127:0] s;
            logic [127:0] r;
            logic [127:0] psi;
            logic [127:0] p2;
            logic [127:0] quo;
            logic [127:0] chi;
            int           n_used;
            t_field_out   res;
            n_used = (active_count > MAX_PUNCTURES) ? MAX_PUNCTURES : active_count;
            psi    = 128'h1_0000;
            for (int n = 0; n < n_used; n++) begin
                s = abs_delta(x, cx_tab[n]) * abs_delta(x, cx_tab[n])
                  + abs_delta(y, cy_tab[n]) * abs_delta(y, cy_tab[n])
                  + abs_delta(z, cz_tab[n]) * abs_delta(z, cz_tab[n]);
                r = {64'd0, int_sqrt(s)};
                if (r == 0)
                    r = 128'd1;
                psi = psi + (({96'd0, mass_tab[n]} << 15) / r);
                if (psi > 128'h7FFF_FFFF)
                    psi = 128'h7FFF_FFFF;
            end
            p2        = psi * psi;
            quo       = (128'd1 << 95) / p2;
            chi       = quo / p2;
            res.chi   = chi[31:0];
            res.lapse = 32'(int_sqrt(chi << 31));
            return res;
        endfunction

        function void note_input(input logic func, input logic [1:0] slot,
                                 input logic [31:0] mass, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z);
            if (func == FUNC_LOAD) begin
                mass_tab[slot] = mass;
                cx_tab[slot]   = x;
                cy_tab[slot]   = y;
                cz_tab[slot]   = z;
            end else begin
                expected_q.push_back(conformal_field(x, y, z));
            end
        endfunction

        function void check_result(input t_field_out got);
            t_field_out want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer chi=%h lapse=%h", got.chi, got.lapse);
                return;
            end
            want = expected_q.pop_front();
            if (got.chi !== want.chi || got.lapse !== want.lapse) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: chi exp %h got %h, lapse exp %h got %h",
                             want.chi, got.chi, want.lapse, got.lapse);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    logic [63:0]  m_axis_tdata;

    puncture_scoreboard field_sb;
    logic        gaps_on;
    int          cycle_count = 0;

    puncture_conformal_factor_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output stalls
    always @(posedge i_clk) begin
        m_axis_tready <= (gaps_on && $urandom_range(0, 99) < 21) ? 1'b0 : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            field_sb.check_result(m_axis_tdata);
    end

    task automatic send_item(input logic func, input logic [1:0] slot,
                             input logic [31:0] mass, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {6'd0, z, y, x, mass, slot};
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        field_sb.note_input(func, slot, mass, x, y, z);
    endtask

    task automatic write_count(input logic [2:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (field_sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        field_sb.active_count = value;
    endtask

    task automatic random_item();
        logic [1:0]  pick;
        logic [31:0] off;
        int          sh;
        if ($urandom_range(0, 99) < 22) begin
            sh = $urandom_range(0, 31);
            send_item(FUNC_LOAD, 2'($urandom_range(0, 3)), $urandom >> sh,
                      $urandom, $urandom, $urandom);
        end else if ($urandom_range(0, 1) == 0) begin
            send_item(FUNC_EVAL, 2'($urandom_range(0, 3)), $urandom,
                      $urandom, $urandom, $urandom);
        end else begin
            // point near one stored center
            pick = 2'($urandom_range(0, 3));
            sh   = $urandom_range(0, 31);
            off  = $urandom >> sh;
            send_item(FUNC_EVAL, 2'($urandom_range(0, 3)), $urandom,
                      field_sb.cx_tab[pick] + off,
                      field_sb.cy_tab[pick] - ($urandom >> sh),
                      field_sb.cz_tab[pick] + ($urandom >> sh));
        end
    endtask

    initial begin
        logic [2:0] phase_count [8];
        field_sb      = new();
        phase_count   = '{3'd1, 3'd4, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd6};
        gaps_on       = 1'b1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 3'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero count: psi stays one
        send_item(FUNC_EVAL, 2'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_item(FUNC_LOAD, 2'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_LOAD, 2'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_item(FUNC_LOAD, 2'd2, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(FUNC_LOAD, 2'd3, 32'h0000_8000, 32'h0002_0000, 32'hFFFE_0000, 32'd0);
        write_count(3'd4);
        // point on a puncture and saturation of psi
        send_item(FUNC_EVAL, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_EVAL, 2'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(FUNC_EVAL, 2'd1, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(FUNC_EVAL, 2'd2, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
        send_item(FUNC_EVAL, 2'd2, 32'd0, 32'h0000_0001, 32'd0, 32'd0);
        send_item(FUNC_LOAD, 2'd1, 32'd1, 32'h4000_0000, 32'h0, 32'h0);
        send_item(FUNC_EVAL, 2'd0, 32'd0, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0100);
        write_count(3'd7);
        send_item(FUNC_EVAL, 2'd0, 32'd0, 32'h0002_0000, 32'hFFFE_0000, 32'd0);
        write_count(3'd1);
        send_item(FUNC_EVAL, 2'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'd0);

        for (int p = 0; p < 8; p++) begin
            write_count(phase_count[p]);
            gaps_on = (p != 2);
            repeat (135) random_item();
        end
        gaps_on = 1'b1;

        s_axis_tvalid <= 1'b0;
        while (field_sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (field_sb.mismatches == 0 && field_sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
